FILE: sv/tccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and codes for the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    typedef enum logic [1:0] {
        OP_READ,
        OP_CR,
        OP_LF,
        OP_CHAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [2:0] read_row;
        logic [4:0] read_col;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_PUT
    } t_state;

endpackage

FILE: sv/tccs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_if
// Valid/ready channels for console commands and results.
// ----------------------------------------------------------------------------
interface tccs_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;
    logic [2:0] read_row;
    logic [4:0] read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_char;
    logic [2:0] cursor_row;
    logic [5:0] cursor_col;
    logic       scrolled;

    modport source (output valid, read_char, cursor_row, cursor_col, scrolled, input ready);
    modport sink   (input valid, read_char, cursor_row, cursor_col, scrolled, output ready);
endinterface

FILE: sv/tccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/tccs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_front
// Accepts command transfers and classifies them for the back end.
// ----------------------------------------------------------------------------
module tccs_front
    import tccs_pkg::*;
(
    tccs_in_if.sink      i_in,
    input  t_back_status i_status,
    input  logic         i_q_full,
    output logic         o_push,
    output t_item        o_item
);
    always_comb begin
        o_item.char_code = i_in.char_code;
        o_item.read_row  = i_in.read_row;
        o_item.read_col  = i_in.read_col;
        priority if (i_in.command) begin
            o_item.op = OP_READ;
        end else if (i_in.char_code == CODE_CR) begin
            o_item.op = OP_CR;
        end else if (i_in.char_code == CODE_LF) begin
            o_item.op = OP_LF;
        end else begin
            o_item.op = OP_CHAR;
        end
    end

    assign i_in.ready = !i_q_full && !i_status.clearing;
    assign o_push     = i_in.valid && i_in.ready;
endmodule

FILE: sv/tccs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module tccs_queue
    import tccs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");
endmodule

FILE: sv/tccs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccs_back
// Executes commands: cursor, circular row base, scroll row clear, screen RAM.
// ----------------------------------------------------------------------------
module tccs_back
    import tccs_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_item         i_q_item,
    output logic          o_q_pop,
    output t_back_status  o_status,
    tccs_out_if.source    o_out
);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CCW   = $clog2(COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);

    t_state          r_state, n_state;
    logic [RW-1:0]   r_row, n_row;
    logic [CCW-1:0]  r_col, n_col;
    logic [RW-1:0]   r_base, n_base;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_is_char, n_is_char;
    logic [7:0]      r_code, n_code;
    logic [7:0]      r_rchar, n_rchar;
    logic            r_scr, n_scr;
    logic            r_out_valid, n_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // logical row to physical row through the circular base
    function automatic logic [RW-1:0] phys(input logic [RW-1:0] x,
                                           input logic [RW-1:0] base);
        logic [RW:0] s;
        s = {1'b0, x} + {1'b0, base};
        if (s >= (RW+1)'(ROWS)) begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    tccs_ram #(
        .W     (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_is_char   <= 1'b0;
            r_scr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_cnt       <= n_cnt;
            r_is_char   <= n_is_char;
            r_scr       <= n_scr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_rchar <= n_rchar;
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_is_char   = r_is_char;
        n_code      = r_code;
        n_rchar     = r_rchar;
        n_scr       = r_scr;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = 8'd0;
        ram_re      = 1'b0;
        ram_raddr   = {phys(RW'(i_q_item.read_row), r_base), CW'(i_q_item.read_col)};
        o_q_pop     = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_scr   = 1'b0;
                    n_rchar = 8'd0;
                    n_code  = i_q_item.char_code;
                    unique case (i_q_item.op)
                        OP_READ: begin
                            if (32'(i_q_item.read_row) < ROWS &&
                                32'(i_q_item.read_col) < COLS) begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_CR: begin
                            n_col       = '0;
                            n_out_valid = 1'b1;
                        end
                        OP_LF: begin
                            n_col = '0;
                            if (r_row == RW'(ROWS - 1)) begin
                                n_base    = phys(RW'(1), r_base);
                                n_cnt     = '0;
                                n_is_char = 1'b0;
                                n_state   = S_SCROLL;
                            end else begin
                                n_row       = r_row + RW'(1);
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_CHAR: begin
                            if (r_col == CCW'(COLS)) begin
                                n_col = '0;
                                if (r_row == RW'(ROWS - 1)) begin
                                    n_base    = phys(RW'(1), r_base);
                                    n_cnt     = '0;
                                    n_is_char = 1'b1;
                                    n_state   = S_SCROLL;
                                end else begin
                                    n_row   = r_row + RW'(1);
                                    n_state = S_PUT;
                                end
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rchar     = ram_rdata;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCROLL: begin
                // new bottom row is the old top row
                ram_we    = 1'b1;
                ram_waddr = {phys(RW'(ROWS - 1), r_base), r_cnt[CW-1:0]};
                if (r_cnt[CW-1:0] == CW'(COLS - 1)) begin
                    n_cnt = '0;
                    n_scr = 1'b1;
                    if (r_is_char) begin
                        n_state = S_PUT;
                    end else begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_PUT: begin
                ram_we      = 1'b1;
                ram_waddr   = {phys(r_row, r_base), r_col[CW-1:0]};
                ram_wdata   = r_code;
                n_col       = r_col + CCW'(1);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status.clearing = (r_state == S_CLEAR);

    assign o_out.valid      = r_out_valid;
    assign o_out.read_char  = r_rchar;
    assign o_out.cursor_row = 3'(r_row);
    assign o_out.cursor_col = 6'(r_col);
    assign o_out.scrolled   = r_scr;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && !r_out_valid)
        else $error("command taken while busy");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CCW'(COLS))
        else $error("cursor column beyond full");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) < ROWS)
        else $error("row base out of range");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_scr) |-> (r_row == RW'(ROWS - 1)))
        else $error("scroll reported off the last row");

    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_col < CCW'(COLS)))
        else $error("character store with full column");
endmodule

FILE: sv/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character screen store with cursor, carriage return, newline and scroll.
// ----------------------------------------------------------------------------
// Results: CR, LF and reads out of range come straight from the idle state; reads pass
//   the read state, characters the put state. A scrolling line advance first clears the
//   new bottom row one cell per cycle in the scroll state, then a character is put.
// Commands: one runs at a time, taken once the last result is accepted; two more queue.
// Reset: cursor and row base go to zero, then all ROWS * 2**clog2(COLS) cells (256 by
//   default) of the screen RAM are zeroed; no command transfer is taken until it ends.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccs_in_if.sink    i_in,
    tccs_out_if.source o_out
);
    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    t_item        front_item;
    t_item        q_item;
    t_back_status back_status;

    tccs_front u_front (
        .i_in     (i_in),
        .i_status (back_status),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    tccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    tccs_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_status  (back_status),
        .o_out     (o_out)
    );
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console. Commands go in over the input
// channel with bursty timing. A behavioral screen model tracks the cells and
// the cursor. It predicts each result, and a checker matches every output
// transfer against the oldest prediction. Directed cases cover reset
// contents, code extremes, CR, LF and scroll. A long output stall and a
// drain pause are applied, then random text lines, reads and noise.
// ----------------------------------------------------------------------------
module testbench;
    import tccs_pkg::*;

    localparam int   ROWS         = 8;
    localparam int   COLS         = 32;
    localparam int   CLK_PERIOD   = 12;
    localparam int   TIMEOUT_NS   = 12_000_000;
    localparam int   RANDOM_ITEMS = 1650;
    localparam int   DRAIN_CYCLES = 80;
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    typedef struct packed {
        logic [7:0] read_char;
        logic [2:0] cursor_row;
        logic [5:0] cursor_col;
        logic       scrolled;
    } t_console_result;

    logic i_clk;
    logic i_rst_n;

    tccs_in_if  cmd_if ();
    tccs_out_if res_if ();

    text_console_cursor_scroll #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    logic [7:0]      screen_cells [ROWS*COLS];
    int              cursor_row;
    int              cursor_col;
    t_console_result pending_results [$];
    int              error_count = 0;
    int              items_sent  = 0;
    int              burst_left  = 0;
    bit              steady_send = 1'b0;
    int              hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------
    function automatic bit next_line();
        cursor_col = 0;
        if (cursor_row >= ROWS - 1) begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_cells[i] = screen_cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                screen_cells[i] = 8'd0;
            cursor_row = ROWS - 1;
            return 1'b1;
        end
        cursor_row++;
        return 1'b0;
    endfunction

    function automatic t_console_result console_step(input logic       cmd,
                                                     input logic [7:0] code,
                                                     input logic [2:0] row,
                                                     input logic [4:0] col);
        t_console_result res;
        bit              did_scroll;
        did_scroll    = 1'b0;
        res.read_char = 8'd0;
        if (cmd == CMD_READ) begin
            if (int'(row) < ROWS && int'(col) < COLS)
                res.read_char = screen_cells[int'(row) * COLS + int'(col)];
        end else if (code == CODE_CR) begin
            cursor_col = 0;
        end else if (code == CODE_LF) begin
            did_scroll = next_line();
        end else begin
            if (cursor_col >= COLS)
                did_scroll = next_line();
            screen_cells[cursor_row * COLS + cursor_col] = code;
            cursor_col++;
        end
        res.cursor_row = cursor_row[2:0];
        res.cursor_col = cursor_col[5:0];
        res.scrolled   = did_scroll;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_item(input logic       cmd,
                             input logic [7:0] code,
                             input logic [2:0] row,
                             input logic [4:0] col);
        int gap;
        if (!steady_send && burst_left == 0) begin
            case ($urandom_range(0, 9))
                0:       gap = $urandom_range(10, 45);
                1, 2, 3: gap = 0;
                default: gap = $urandom_range(1, 4);
            endcase
            burst_left = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= cmd;
        cmd_if.char_code <= code;
        cmd_if.read_row  <= row;
        cmd_if.read_col  <= col;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(console_step(cmd, code, row, col));
        items_sent++;
    endtask

    task automatic send_write(input logic [7:0] code);
        send_item(CMD_WRITE, code, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
    endtask

    task automatic send_read(input logic [2:0] row, input logic [4:0] col);
        send_item(CMD_READ, 8'($urandom_range(0, 255)), row, col);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= (phase % 5 < 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: read_char=%0d cursor_row=%0d cursor_col=%0d scrolled=%0d",
                       res_if.read_char, res_if.cursor_row, res_if.cursor_col,
                       res_if.scrolled);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.read_char !== want.read_char) begin
                    $error("read_char: expected %0d, got %0d", want.read_char, res_if.read_char);
                    error_count++;
                end
                if (res_if.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d",
                           want.cursor_row, res_if.cursor_row);
                    error_count++;
                end
                if (res_if.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d",
                           want.cursor_col, res_if.cursor_col);
                    error_count++;
                end
                if (res_if.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, res_if.scrolled);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_contents();
        send_read(3'd0, 5'd0);
        send_read(3'd7, 5'd31);
        send_read(3'd0, 5'd31);
        send_read(3'd7, 5'd0);
    endtask

    task automatic test_code_extremes();
        send_write(8'h00);
        send_write(8'hFF);
        send_read(3'd0, 5'd0);
        send_read(3'd0, 5'd1);
        send_write(CODE_CR);
        send_write(8'h41);
        send_read(3'd0, 5'd0);
    endtask

    task automatic test_newline_scroll();
        repeat (7) send_write(CODE_LF);
        send_write(8'h5A);
        send_write(CODE_LF);
        send_read(3'd6, 5'd0);
        send_read(3'd7, 5'd0);
    endtask

    // output held off long enough for the input side to back up
    task automatic test_output_hold();
        hold_cycles = 300;
        steady_send = 1'b1;
        repeat (40) send_write(8'($urandom_range(32, 126)));
        steady_send = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (12) send_write(8'($urandom_range(0, 255)));
        release_input();
        wait_for_results();
        repeat (8) send_read(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)));
    endtask

    task automatic test_random_text();
        int         len;
        logic [7:0] code;
        logic [2:0] row;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                      : $urandom_range(0, 20);
                    repeat (len) begin
                        code = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(32, 126));
                        send_write(code);
                    end
                    case ($urandom_range(0, 3))
                        0: ;
                        1: send_write(CODE_LF);
                        2: send_write(CODE_CR);
                        default: begin
                            send_write(CODE_CR);
                            send_write(CODE_LF);
                        end
                    endcase
                end
                6, 7, 8: begin
                    repeat ($urandom_range(1, 6)) begin
                        row = ($urandom_range(0, 1) == 0) ? cursor_row[2:0]
                                                          : 3'($urandom_range(0, 7));
                        send_read(row, 5'($urandom_range(0, 31)));
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(0, 2))
                            0:       send_write(CODE_CR);
                            1:       send_write(CODE_LF);
                            default: send_write(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
            endcase
        end
    endtask

    initial begin
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= CMD_WRITE;
        cmd_if.char_code <= 8'd0;
        cmd_if.read_row  <= 3'd0;
        cmd_if.read_col  <= 5'd0;
        i_rst_n          <= 1'b0;
        foreach (screen_cells[i])
            screen_cells[i] = 8'd0;
        cursor_row = 0;
        cursor_col = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_code_extremes();
        test_newline_scroll();
        test_output_hold();
        test_drain_pause();
        test_random_text();

        release_input();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
